[rtl/csqrt_pkg.sv]
// Shared types and constants for the complex square root block.
package csqrt_pkg;

    localparam int DATA_W     = 32;
    localparam int ROOT_R_W   = 31;
    localparam int HALF_SHIFT = 15;

    typedef struct packed {
        logic signed [DATA_W-1:0] real_part;
        logic signed [DATA_W-1:0] imag_part;
    } op_item_t;

    typedef struct packed {
        logic        [ROOT_R_W-1:0] root_real;
        logic signed [DATA_W-1:0]   root_imag;
    } res_item_t;

    // Operand after classification: magnitudes and the flags that pick the branch.
    typedef struct packed {
        logic [DATA_W-1:0] mag_a;
        logic [DATA_W-1:0] mag_b;
        logic              a_pos;
        logic              b_neg;
        logic              zero;
    } cls_item_t;

endpackage

[rtl/csqrt_isqrt.sv]
// Pipelined integer square root, one result bit per stage, with a sideband.
module csqrt_isqrt
    import csqrt_pkg::*;
#(
    parameter int RAD_W  = 64,
    parameter int SIDE_W = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_vld,
    input  logic [RAD_W-1:0]       radicand,
    input  logic [SIDE_W-1:0]      side_in,
    output logic                   out_vld,
    output logic [RAD_W/2-1:0]     root,
    output logic [SIDE_W-1:0]      side_out
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic [RAD_W-1:0]  rad_reg  [0:ROOT_W];
    logic [REM_W-1:0]  rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W];
    logic [SIDE_W-1:0] side_reg [0:ROOT_W];
    logic              vld_reg  [0:ROOT_W];

    assign rad_reg[0]  = radicand;
    assign rem_reg[0]  = '0;
    assign root_reg[0] = '0;
    assign side_reg[0] = side_in;
    assign vld_reg[0]  = in_vld;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  sub;
        logic              fits;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        always_comb
        begin
            // The remainder before the shift never exceeds ROOT_W bits.
            trial     = {rem_reg[g][REM_W-3:0], rad_reg[g][RAD_W-1 -: 2]};
            sub       = {root_reg[g], 2'b01};
            fits      = trial >= sub;
            rem_next  = fits ? (trial - sub) : trial;
            root_next = {root_reg[g][ROOT_W-2:0], fits};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[g+1] <= vld_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[g+1]  <= {rad_reg[g][RAD_W-3:0], 2'b00};
                rem_reg[g+1]  <= rem_next;
                root_reg[g+1] <= root_next;
                side_reg[g+1] <= side_reg[g];
            end
        end
    end

    assign out_vld  = vld_reg[ROOT_W];
    assign root     = root_reg[ROOT_W];
    assign side_out = side_reg[ROOT_W];

endmodule

[rtl/csqrt_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
module csqrt_div
    import csqrt_pkg::*;
#(
    parameter int DVD_W  = 47,
    parameter int DVS_W  = 24,
    parameter int SIDE_W = 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [DVS_W-1:0]  divisor,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_vld,
    output logic [DVD_W-1:0]  quotient,
    output logic [DVS_W-1:0]  divisor_out,
    output logic [SIDE_W-1:0] side_out
);

    logic [DVD_W-1:0]  dvd_reg  [0:DVD_W];
    logic [DVS_W-1:0]  dvs_reg  [0:DVD_W];
    logic [DVS_W-1:0]  rem_reg  [0:DVD_W];
    logic [DVD_W-1:0]  quot_reg [0:DVD_W];
    logic [SIDE_W-1:0] side_reg [0:DVD_W];
    logic              vld_reg  [0:DVD_W];

    assign dvd_reg[0]  = dividend;
    assign dvs_reg[0]  = divisor;
    assign rem_reg[0]  = '0;
    assign quot_reg[0] = '0;
    assign side_reg[0] = side_in;
    assign vld_reg[0]  = in_vld;

    for (genvar g = 0; g < DVD_W; g++) begin : g_stage
        logic [DVS_W:0]   trial;
        logic             fits;
        logic [DVS_W:0]   diff;
        logic [DVS_W-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[g], dvd_reg[g][DVD_W-1]};
            fits     = trial >= {1'b0, dvs_reg[g]};
            diff     = trial - {1'b0, dvs_reg[g]};
            rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[g+1] <= vld_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dvd_reg[g+1]  <= {dvd_reg[g][DVD_W-2:0], 1'b0};
                dvs_reg[g+1]  <= dvs_reg[g];
                rem_reg[g+1]  <= rem_next;
                quot_reg[g+1] <= {quot_reg[g][DVD_W-2:0], fits};
                side_reg[g+1] <= side_reg[g];
            end
        end
    end

    assign out_vld     = vld_reg[DVD_W];
    assign quotient    = quot_reg[DVD_W];
    assign divisor_out = dvs_reg[DVD_W];
    assign side_out    = side_reg[DVD_W];

endmodule

[rtl/csqrt_front.sv]
// Front end: accepts operands, takes magnitudes and sets the branch flags.
module csqrt_front
    import csqrt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      op_valid,
    output logic      op_ready,
    input  op_item_t  op_data,
    output logic      push_valid,
    input  logic      push_ready,
    output cls_item_t push_data
);

    cls_item_t cls_reg;
    cls_item_t cls_next;
    logic      vld_reg;

    always_comb
    begin
        cls_next.mag_a = op_data.real_part[DATA_W-1] ? (~op_data.real_part + 1'b1)
                                                     : op_data.real_part;
        cls_next.mag_b = op_data.imag_part[DATA_W-1] ? (~op_data.imag_part + 1'b1)
                                                     : op_data.imag_part;
        cls_next.a_pos = !op_data.real_part[DATA_W-1] && (op_data.real_part != '0);
        cls_next.b_neg = op_data.imag_part[DATA_W-1];
        cls_next.zero  = (op_data.real_part == '0) && (op_data.imag_part == '0);
    end

    assign op_ready   = !vld_reg || push_ready;
    assign push_valid = vld_reg;
    assign push_data  = cls_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (op_ready)
        begin
            vld_reg <= op_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_ready && op_valid)
        begin
            cls_reg <= cls_next;
        end
    end

endmodule

[rtl/csqrt_queue.sv]
// Short first-in first-out queue between the front end and the datapath.
module csqrt_queue
    import csqrt_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  cls_item_t push_data,
    output logic      pop_valid,
    input  logic      pop_ready,
    output cls_item_t pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cls_item_t        mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign count_next = count_reg + CNT_W'(push) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/csqrt_back.sv]
// Back end: magnitude, two square roots, the quotient and the result register.
module csqrt_back
    import csqrt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  cls_item_t pop_data,
    output logic      res_valid,
    input  logic      res_ready,
    output res_item_t res_data
);

    localparam int SQ_W   = 2 * DATA_W;
    localparam int M_W    = SQ_W / 2;
    localparam int S_W    = M_W + 1;
    localparam int RAD2_W = S_W + HALF_SHIFT;
    localparam int T_W    = RAD2_W / 2;
    localparam int DVD_W  = DATA_W + HALF_SHIFT;

    typedef struct packed {
        logic a_pos;
        logic b_neg;
        logic zero;
    } flags_t;

    typedef struct packed {
        logic [DATA_W-1:0] mag_a;
        logic [DATA_W-1:0] mag_b;
        flags_t            flags;
    } side1_t;

    typedef struct packed {
        logic [DATA_W-1:0] mag_b;
        flags_t            flags;
    } side2_t;

    logic              en;
    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;
    logic [SQ_W-1:0]   sqa_reg;
    logic [SQ_W-1:0]   sqb_reg;
    logic [SQ_W-1:0]   sum_reg;
    side1_t            s1_reg;
    side1_t            s2_reg;
    logic              r1_vld;
    logic [M_W-1:0]    mag;
    side1_t            r1_side;
    logic [S_W-1:0]    s_reg;
    side2_t            s3_reg;
    logic              r2_vld;
    logic [T_W-1:0]    t_root;
    side2_t            r2_side;
    logic              d_vld;
    logic [DVD_W-1:0]  quot;
    logic [T_W-1:0]    t_out;
    flags_t            d_flags;
    res_item_t         res_next;
    res_item_t         res_reg;
    logic              res_vld_reg;

    // Encodes a magnitude and a sign as 32-bit two's complement, saturating.
    function automatic logic [DATA_W-1:0] enc_signed(input logic [DVD_W-1:0] m,
                                                      input logic neg);
        logic [DVD_W-1:0] lim;
        begin
            lim = DVD_W'({1'b1, {(DATA_W-1){1'b0}}});
            if (neg)
            begin
                enc_signed = (m > lim) ? lim[DATA_W-1:0] : (~m[DATA_W-1:0] + 1'b1);
            end
            else
            begin
                enc_signed = (m >= lim) ? {1'b0, {(DATA_W-1){1'b1}}} : m[DATA_W-1:0];
            end
        end
    endfunction

    // The whole datapath advances together whenever the result register can move.
    assign en        = !res_vld_reg || res_ready;
    assign pop_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg      <= pop_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= r1_vld;
            res_vld_reg <= d_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqa_reg <= pop_data.mag_a * pop_data.mag_a;
            sqb_reg <= pop_data.mag_b * pop_data.mag_b;
            s1_reg  <= '{pop_data.mag_a, pop_data.mag_b,
                         '{pop_data.a_pos, pop_data.b_neg, pop_data.zero}};
            sum_reg <= sqa_reg + sqb_reg;
            s2_reg  <= s1_reg;
            s_reg   <= {1'b0, mag} + {1'b0, r1_side.mag_a};
            s3_reg  <= '{r1_side.mag_b, r1_side.flags};
            res_reg <= res_next;
        end
    end

    csqrt_isqrt #(
        .RAD_W  (SQ_W),
        .SIDE_W ($bits(side1_t))
    ) u_mag_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (v2_reg),
        .radicand (sum_reg),
        .side_in  (s2_reg),
        .out_vld  (r1_vld),
        .root     (mag),
        .side_out (r1_side)
    );

    csqrt_isqrt #(
        .RAD_W  (RAD2_W),
        .SIDE_W ($bits(side2_t))
    ) u_half_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (v3_reg),
        .radicand ({s_reg, {HALF_SHIFT{1'b0}}}),
        .side_in  (s3_reg),
        .out_vld  (r2_vld),
        .root     (t_root),
        .side_out (r2_side)
    );

    csqrt_div #(
        .DVD_W  (DVD_W),
        .DVS_W  (T_W),
        .SIDE_W ($bits(flags_t))
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_vld      (r2_vld),
        .dividend    ({r2_side.mag_b, {HALF_SHIFT{1'b0}}}),
        .divisor     (t_root),
        .side_in     (r2_side.flags),
        .out_vld     (d_vld),
        .quotient    (quot),
        .divisor_out (t_out),
        .side_out    (d_flags)
    );

    always_comb
    begin
        if (d_flags.zero)
        begin
            res_next = '0;
        end
        else if (d_flags.a_pos)
        begin
            res_next.root_real = ROOT_R_W'(t_out);
            res_next.root_imag = enc_signed(quot, d_flags.b_neg);
        end
        else
        begin
            res_next.root_real = (quot > DVD_W'({ROOT_R_W{1'b1}})) ? {ROOT_R_W{1'b1}}
                                                                  : quot[ROOT_R_W-1:0];
            res_next.root_imag = enc_signed(DVD_W'(t_out), d_flags.b_neg);
        end
    end

    assign res_valid = res_vld_reg;
    assign res_data  = res_reg;

endmodule

[rtl/complex_square_root.sv]
// Top level of the complex principal square root in signed Q16.16.
// One operand is accepted per clock and one result leaves per clock while no
// finished result waits; each transaction passes through the bit-per-stage
// magnitude root (32 stages), half-sum root (24 stages) and divider (47 stages)
// plus the front register and the squaring, sum, half-sum and result registers.
// The datapath stalls as a whole while a finished result waits; the queue
// behind the front end keeps taking operands until it is full.
module complex_square_root
    import csqrt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      op_valid,
    output logic      op_ready,
    input  op_item_t  op_data,
    output logic      res_valid,
    input  logic      res_ready,
    output res_item_t res_data
);

    logic      q_push_valid;
    logic      q_push_ready;
    cls_item_t q_push_data;
    logic      q_pop_valid;
    logic      q_pop_ready;
    cls_item_t q_pop_data;

    csqrt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (op_valid),
        .op_ready   (op_ready),
        .op_data    (op_data),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data)
    );

    csqrt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    csqrt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_data  (q_pop_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // The queue can never be empty and full at the same time.
    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop_valid || q_push_ready)
        else $error("queue reports empty and full together");

    // The front end refuses an operand only when the queue is full.
    a_front_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !op_ready |-> !q_push_ready)
        else $error("front end stalled with room in the queue");

    // The datapath draws from the queue only when the result register can move.
    a_pop_gate: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |-> !q_pop_ready)
        else $error("queue popped while the result was held");

endmodule
